FILE: rtl/cmtq_pkg.sv
// Shared types and constants for the timer queue.
`timescale 1ns / 1ps

package cmtq_pkg;

  localparam int SLOTS       = 16;
  localparam int ID_BITS     = 16;
  localparam int MAX_RESULTS = 16;
  localparam int SLOT_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);
  localparam int TIMER_ID_W  = 16;
  localparam int CANCEL_ID_W = 16;
  localparam int DELAY_W     = 24;
  localparam int TIME_W      = 32;
  localparam int MIN_DELAY_W = 8;

  localparam logic [1:0] OP_SCHEDULE = 2'd0;
  localparam logic [1:0] OP_CANCEL   = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;

  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [MIN_DELAY_W-1:0] MIN_DELAY_RESET = 8'd1;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [DELAY_W-1:0]     delay;
    logic [CANCEL_ID_W-1:0] cancel_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [TIMER_ID_W-1:0] timer_id;
    logic [TIME_W-1:0]     deadline;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic tick;
    logic scan_clr;
    logic scan_step;
    logic cancel_step;
    logic sched_write;
    logic take_best;
    logic emit_pend;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic best_found;
    logic scan_last;
  } status_t;

endpackage

FILE: rtl/cmtq_ctl.sv
// Controller state machine for the timer queue.
`timescale 1ns / 1ps

module cmtq_ctl import cmtq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  input  status_t    status,
  output logic       in_ready,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCHED,
    ST_CANCEL,
    ST_SCAN,
    ST_DECIDE,
    ST_FLUSH
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] count_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    count_next = count;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          unique case (in_op)
            OP_SCHEDULE: state_next = ST_SCHED;
            OP_CANCEL: begin
              cmd.scan_clr = 1'b1;
              state_next   = ST_CANCEL;
            end
            OP_TICK: begin
              cmd.tick     = 1'b1;
              cmd.scan_clr = 1'b1;
              count_next   = '0;
              state_next   = ST_SCAN;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCHED: begin
        if (status.out_free) begin
          cmd.sched_write = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_CANCEL: begin
        cmd.cancel_step = 1'b1;
        if (status.scan_last) state_next = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status.best_found) begin
          if (count == '0 || status.out_free) begin
            cmd.take_best = 1'b1;
            cmd.emit_pend = (count != '0);
            count_next    = count + 1'b1;
            if (count == CNT_BITS'(MAX_RESULTS - 1)) begin
              state_next = ST_FLUSH;
            end else begin
              cmd.scan_clr = 1'b1;
              state_next   = ST_SCAN;
            end
          end
        end else if (count == '0) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd.emit_pend = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_pend || cmd.sched_write) |-> status.out_free)
    else $error("emit issued while output register busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(MAX_RESULTS))
    else $error("fired count exceeds limit");

  a_flush_has_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> (count != '0))
    else $error("flush without pending item");

endmodule

FILE: rtl/cmtq_dp.sv
// Datapath for the timer queue: slot table, clock, scan unit and output register.
`timescale 1ns / 1ps

module cmtq_dp import cmtq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic                   cfg_valid,
  input  logic [MIN_DELAY_W-1:0] cfg_data,
  input  in_item_t               in_item,
  input  logic                   out_stall,
  output logic                   out_valid,
  output out_item_t              out_item
);

  logic [MIN_DELAY_W-1:0] min_delay;
  logic [TIME_W-1:0]      cur_time;
  logic [ID_BITS-1:0]     next_ident;
  logic [SLOTS-1:0]       slot_valid;
  logic [TIME_W-1:0]      slot_deadline [SLOTS];
  logic [ID_BITS-1:0]     slot_ident [SLOTS];
  in_item_t               in_reg;
  logic [SLOT_BITS-1:0]   idx;
  logic                   best_found;
  logic [SLOT_BITS-1:0]   best_idx;
  logic [TIME_W-1:0]      best_age;
  logic [ID_BITS-1:0]     best_id;
  logic [TIME_W-1:0]      best_dl;
  logic [ID_BITS-1:0]     pend_id;
  logic [TIME_W-1:0]      pend_dl;

  logic [SLOT_BITS-1:0]   free_idx;
  logic                   full;
  logic [DELAY_W-1:0]     min_ext;
  logic [DELAY_W-1:0]     delay_eff;
  logic [TIME_W-1:0]      sched_dl;
  logic [TIME_W-1:0]      age;
  logic                   due;
  logic                   better;
  logic [ID_BITS-1:0]     cid;
  logic                   out_free;

  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) free_idx = SLOT_BITS'(i);
    end
  end

  assign full      = &slot_valid;
  assign min_ext   = DELAY_W'(min_delay);
  assign delay_eff = (in_reg.delay < min_ext) ? min_ext : in_reg.delay;
  assign sched_dl  = cur_time + TIME_W'(delay_eff);
  assign age       = cur_time - slot_deadline[idx];
  assign due       = slot_valid[idx] && !age[TIME_W-1];
  assign better    = !best_found || (age > best_age) ||
                     ((age == best_age) && (slot_ident[idx] < best_id));
  assign cid       = ID_BITS'(in_reg.cancel_id);
  assign out_free  = !out_valid || !out_stall;

  assign status.out_free   = out_free;
  assign status.best_found = best_found;
  assign status.scan_last  = (idx == SLOT_BITS'(SLOTS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      min_delay  <= MIN_DELAY_RESET;
      cur_time   <= '0;
      next_ident <= '0;
      slot_valid <= '0;
      idx        <= '0;
      best_found <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) min_delay <= cfg_data;
      if (cmd.load_in) in_reg <= in_item;
      if (cmd.tick) cur_time <= cur_time + 1'b1;

      if (cmd.scan_clr) begin
        idx        <= '0;
        best_found <= 1'b0;
      end else if (cmd.scan_step || cmd.cancel_step) begin
        idx <= status.scan_last ? '0 : idx + 1'b1;
      end

      if (cmd.scan_step && due && better) begin
        best_found <= 1'b1;
        best_idx   <= idx;
        best_age   <= age;
        best_id    <= slot_ident[idx];
        best_dl    <= slot_deadline[idx];
      end

      if (cmd.cancel_step && slot_valid[idx] && (slot_ident[idx] == cid)) begin
        slot_valid[idx] <= 1'b0;
      end

      if (cmd.take_best) begin
        slot_valid[best_idx] <= 1'b0;
        pend_id              <= best_id;
        pend_dl              <= best_dl;
      end

      if (cmd.sched_write && !full) begin
        slot_valid[free_idx]    <= 1'b1;
        slot_deadline[free_idx] <= sched_dl;
        slot_ident[free_idx]    <= next_ident;
        next_ident              <= next_ident + 1'b1;
      end

      if (cmd.sched_write || cmd.emit_pend) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end

    if (cmd.sched_write) begin
      out_item.kind     <= full ? KIND_REJECT : KIND_ACK;
      out_item.timer_id <= full ? '0 : TIMER_ID_W'(next_ident);
      out_item.deadline <= sched_dl;
      out_item.last     <= 1'b1;
    end else if (cmd.emit_pend) begin
      out_item.kind     <= KIND_FIRED;
      out_item.timer_id <= TIMER_ID_W'(pend_id);
      out_item.deadline <= pend_dl;
      out_item.last     <= cmd.emit_last;
    end
  end

  a_take_live_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.take_best |-> slot_valid[best_idx])
    else $error("fired slot is not live");

  a_sched_fills_one: assert property (@(posedge clk) disable iff (rst)
    (cmd.sched_write && !full) |=>
      ($countones(slot_valid) == $countones($past(slot_valid)) + 1))
    else $error("schedule did not fill exactly one slot");

  a_take_frees_one: assert property (@(posedge clk) disable iff (rst)
    cmd.take_best |=>
      ($countones(slot_valid) + 1 == $countones($past(slot_valid))))
    else $error("fire did not free exactly one slot");

endmodule

FILE: rtl/cancellable_multi_timer_queue.sv
// Top level of the cancellable multi-timer queue.
//
//   port group  direction  handshake            payload
//   in          input      in_valid / in_stall  in_item   (in_item_t)
//   out         output     out_valid / out_stall out_item (out_item_t)
//   cfg         input      cfg_valid / cfg_ready cfg_data (min_delay)
//
// Schedule: the item is accepted, then the slot is written and the result loaded once the output is free.
// Cancel: the item is accepted, then one slot compare per cycle over all SLOTS slots.
// Tick: accept the item, then one scan of all slots and a pick per fired timer, a closing empty
//   scan unless MAX_RESULTS fired, and an emit of the last item if any fired.
// Reset clears slot valid bits, time, id counter and min_delay (to 1) at once.
// A stalled output holds the controller at its next emit step; input is taken
//   only while the controller is idle.
`timescale 1ns / 1ps

module cancellable_multi_timer_queue import cmtq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [MIN_DELAY_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_stall  = !in_ready;
  assign cfg_ready = 1'b1;

  cmtq_ctl u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_item.opcode),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  cmtq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: tb/sv/cancellable_multi_timer_queue_tb.sv
// Self-checking testbench for the cancellable multi-timer queue.
`timescale 1ns / 1ps

module cancellable_multi_timer_queue_tb;
  import cmtq_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
  localparam int PHASE_ITEMS   = 38;
  localparam int REPORT_CAP    = 50;

  typedef struct packed {
    logic                   cfg_row;
    logic [MIN_DELAY_W-1:0] cfg_val;
    in_item_t               it;
    logic                   typed;
    out_item_t              res;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_item = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_item;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [MIN_DELAY_W-1:0] cfg_data = '0;

  bit                     live [SLOTS];
  logic [TIME_W-1:0]      dl_tab [SLOTS];
  logic [TIMER_ID_W-1:0]  id_tab [SLOTS];
  logic [TIME_W-1:0]      now_t = '0;
  logic [TIMER_ID_W-1:0]  id_next = '0;
  logic [MIN_DELAY_W-1:0] min_dly = MIN_DELAY_RESET;

  out_item_t              step_res [$];
  out_item_t              due_q [$];
  plan_row_t              plan [$];
  out_item_t              want;

  int                     mismatches = 0;
  bit                     tx_idle = 1'b1;
  bit                     rx_idle = 1'b1;
  bit                     out_took = 1'b0;
  int                     stall_left = 0;
  int                     hold_req = 0;

  cancellable_multi_timer_queue dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  initial begin
    #(200_000_000);
    $display("== FAIL ==");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    if (mismatches < REPORT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  function automatic in_item_t as_item(input logic [1:0] op, input logic [DELAY_W-1:0] dly,
                                       input logic [CANCEL_ID_W-1:0] cid);
    in_item_t it;
    it.opcode    = op;
    it.delay     = dly;
    it.cancel_id = cid;
    return it;
  endfunction

  function automatic plan_row_t op_row(input logic [1:0] op, input logic [DELAY_W-1:0] dly,
                                       input logic [CANCEL_ID_W-1:0] cid);
    plan_row_t r;
    r    = '0;
    r.it = as_item(op, dly, cid);
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic [1:0] op, input logic [DELAY_W-1:0] dly,
                                          input logic [CANCEL_ID_W-1:0] cid,
                                          input logic [1:0] kind,
                                          input logic [TIMER_ID_W-1:0] id,
                                          input logic [TIME_W-1:0] dl);
    plan_row_t r;
    r              = op_row(op, dly, cid);
    r.typed        = 1'b1;
    r.res.kind     = kind;
    r.res.timer_id = id;
    r.res.deadline = dl;
    r.res.last     = 1'b1;
    return r;
  endfunction

  // Work out the results of one item and advance the timer table.
  task automatic timer_model(input in_item_t it);
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] dl;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] best_age;
    int                slot;
    int                best;
    bit                hunting;
    out_item_t         r;
    step_res.delete();
    case (it.opcode)
      OP_SCHEDULE: begin
        span = (it.delay < DELAY_W'(min_dly)) ? TIME_W'(min_dly) : TIME_W'(it.delay);
        dl   = now_t + span;
        slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!live[i]) slot = i;
        end
        r          = '0;
        r.deadline = dl;
        r.last     = 1'b1;
        if (slot < 0) begin
          r.kind = KIND_REJECT;
        end else begin
          live[slot]   = 1'b1;
          dl_tab[slot] = dl;
          id_tab[slot] = id_next;
          r.kind       = KIND_ACK;
          r.timer_id   = id_next;
          id_next      = id_next + 1'b1;
        end
        step_res.push_back(r);
      end
      OP_CANCEL: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (live[i] && id_tab[i] == it.cancel_id) live[i] = 1'b0;
        end
      end
      OP_TICK: begin
        now_t   = now_t + 1'b1;
        hunting = 1'b1;
        while (hunting && step_res.size() < MAX_RESULTS) begin
          best     = -1;
          best_age = '0;
          for (int i = 0; i < SLOTS; i++) begin
            age = now_t - dl_tab[i];
            if (live[i] && !age[TIME_W-1]) begin
              if (best < 0 || age > best_age ||
                  (age == best_age && id_tab[i] < id_tab[best])) begin
                best     = i;
                best_age = age;
              end
            end
          end
          if (best < 0) begin
            hunting = 1'b0;
          end else begin
            live[best] = 1'b0;
            r          = '0;
            r.kind     = KIND_FIRED;
            r.timer_id = id_tab[best];
            r.deadline = dl_tab[best];
            step_res.push_back(r);
          end
        end
        if (step_res.size() != 0) begin
          r      = step_res.pop_back();
          r.last = 1'b1;
          step_res.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // Offer one item, after a random gap when tx_idle is set; hold it until accepted.
  task automatic push_item(input in_item_t it, input bit typed, input out_item_t known);
    int gap;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    timer_model(it);
    if (typed) begin
      due_q.push_back(known);
    end else begin
      foreach (step_res[k]) due_q.push_back(step_res[k]);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain all pending results, then give the block time to finish a scan.
  task automatic settle();
    in_valid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_min_delay(input logic [MIN_DELAY_W-1:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    min_dly = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic cancel_all_live();
    for (int s = 0; s < SLOTS; s++) begin
      if (live[s]) push_item(as_item(OP_CANCEL, '0, id_tab[s]), 1'b0, '0);
    end
  endtask

  function automatic in_item_t pick_item();
    in_item_t it;
    int       r;
    int       k;
    it.delay     = DELAY_W'($urandom);
    it.cancel_id = CANCEL_ID_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 42) begin
      it.opcode = OP_SCHEDULE;
      if ($urandom_range(0, 9) != 0) it.delay = DELAY_W'($urandom_range(0, 6));
    end else if (r < 60) begin
      it.opcode = OP_CANCEL;
      k = $urandom_range(0, SLOTS - 1);
      if (live[k] && $urandom_range(0, 3) != 0) it.cancel_id = id_tab[k];
    end else if (r < 96) begin
      it.opcode = OP_TICK;
    end else begin
      it.opcode = OP_UNUSED;
    end
    return it;
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      out_took = 1'b1;
      if (due_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected item kind %0d id %0d", out_item.kind,
                                out_item.timer_id));
      end else begin
        want = due_q.pop_front();
        if (out_item.kind !== want.kind)
          flag_mismatch($sformatf("kind %0d, want %0d", out_item.kind, want.kind));
        if (out_item.timer_id !== want.timer_id)
          flag_mismatch($sformatf("timer_id %0d, want %0d", out_item.timer_id, want.timer_id));
        if (out_item.deadline !== want.deadline)
          flag_mismatch($sformatf("deadline %0d, want %0d", out_item.deadline, want.deadline));
        if (out_item.last !== want.last)
          flag_mismatch($sformatf("last %0b, want %0b", out_item.last, want.last));
      end
    end
  end

  always @(negedge clk) begin
    if (out_took) begin
      out_took   = 1'b0;
      stall_left = rx_idle ? $urandom_range(0, 16) : 0;
    end
    if (hold_req != 0) begin
      stall_left = hold_req;
      hold_req   = 0;
    end
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  initial begin
    int                     n;
    int                     ph;
    logic [MIN_DELAY_W-1:0] knob;

    plan.push_back(known_row(OP_SCHEDULE, '0, '0, KIND_ACK, 16'd0, 32'd1));
    plan.push_back(known_row(OP_SCHEDULE, '1, '0, KIND_ACK, 16'd1, 32'h00FF_FFFF));
    plan.push_back(known_row(OP_TICK, '0, '0, KIND_FIRED, 16'd0, 32'd1));
    plan.push_back(op_row(OP_CANCEL, '0, 16'd1));
    plan.push_back(op_row(OP_CANCEL, '0, '1));
    plan.push_back(op_row(OP_UNUSED, '1, '1));
    plan.push_back(op_row(OP_TICK, '0, '0));
    for (n = 0; n < SLOTS; n++) plan.push_back(op_row(OP_SCHEDULE, DELAY_W'(n % 5), '0));
    plan.push_back(known_row(OP_SCHEDULE, 24'h00ABCD, '0, KIND_REJECT, 16'd0, 32'h0000_ABCF));
    plan.push_back(op_row(OP_TICK, '0, '0));
    plan.push_back('{cfg_row: 1'b1, cfg_val: 8'd0, default: '0});
    plan.push_back(op_row(OP_SCHEDULE, '0, '0));
    plan.push_back(op_row(OP_TICK, '0, '0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].cfg_row) begin
        settle();
        write_min_delay(plan[i].cfg_val);
      end else begin
        push_item(plan[i].it, plan[i].typed, plan[i].res);
      end
    end

    for (ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0:       knob = 8'd0;
        1:       knob = MIN_DELAY_W'($urandom_range(2, 40));
        2:       knob = 8'd1;
        3:       knob = 8'hFF;
        4:       knob = MIN_DELAY_W'($urandom);
        default: knob = 8'd3;
      endcase
      write_min_delay(knob);
      tx_idle = (ph != 5) && (ph != 1);
      rx_idle = (ph != 5) && (ph != 4);
      if (ph == 2) hold_req = 400;
      for (n = 0; n < PHASE_ITEMS; n++) push_item(pick_item(), 1'b0, '0);
      if (ph == 3) cancel_all_live();
    end

    settle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
